[hdl/source_tokenizer_macros.svh]
// Assertion helpers shared by the tokenizer RTL.
// Each macro expands to one labeled concurrent assertion on clk_i.
`ifndef SOURCE_TOKENIZER_MACROS_SVH
`define SOURCE_TOKENIZER_MACROS_SVH

// Checked only while out of reset.
`define STOK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define STOK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hdl/stok_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package stok_pkg;

  // Width of the line, column and length counters.
  localparam int unsigned CountWidth = 16;
  // Result queue depth, a power of two of at least 2.
  localparam int unsigned QueueDepth = 4;

  typedef logic [CountWidth-1:0] count_t;

  typedef enum logic [5:0] {
    TokEnd    = 6'd0,
    TokIdent  = 6'd1,
    TokNumber = 6'd2,
    TokString = 6'd3,
    TokLet    = 6'd4,
    TokFn     = 6'd5,
    TokIf     = 6'd6,
    TokElse   = 6'd7,
    TokWhile  = 6'd8,
    TokReturn = 6'd9,
    TokTrue   = 6'd10,
    TokFalse  = 6'd11,
    TokLParen = 6'd12,
    TokRParen = 6'd13,
    TokLBrace = 6'd14,
    TokRBrace = 6'd15,
    TokColon  = 6'd16,
    TokSemi   = 6'd17,
    TokComma  = 6'd18,
    TokPlus   = 6'd19,
    TokMinus  = 6'd20,
    TokStar   = 6'd21,
    TokSlash  = 6'd22,
    TokPct    = 6'd23,
    TokBang   = 6'd24,
    TokNe     = 6'd25,
    TokAssign = 6'd26,
    TokEqEq   = 6'd27,
    TokAmp    = 6'd28,
    TokAndAnd = 6'd29,
    TokPipe   = 6'd30,
    TokOrOr   = 6'd31,
    TokCaret  = 6'd32,
    TokLt     = 6'd33,
    TokShl    = 6'd34,
    TokLe     = 6'd35,
    TokGt     = 6'd36,
    TokShr    = 6'd37,
    TokGe     = 6'd38
  } kind_e;

  typedef enum logic [1:0] {
    ErrNone        = 2'd0,
    ErrUnexpected  = 2'd1,
    ErrOpenComment = 2'd2,
    ErrOpenString  = 2'd3
  } err_e;

  // Keywords packed first byte highest, as the identifier buffer holds them.
  localparam int unsigned NumKeywords = 8;
  localparam logic [47:0] KwText [NumKeywords] = '{
    48'h6C6574, 48'h666E, 48'h6966, 48'h656C7365,
    48'h7768696C65, 48'h72657475726E, 48'h74727565, 48'h66616C7365
  };
  localparam logic [2:0] KwLen [NumKeywords] = '{
    3'd3, 3'd2, 3'd2, 3'd4, 3'd5, 3'd6, 3'd4, 3'd5
  };
  localparam logic [2:0] KwMaxLen = 3'd6;

  typedef struct packed {
    kind_e       kind;
    err_e        err;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] length;
    logic        last;
  } result_t;

  // Up to two results written to the queue in one cycle; entry1 only with entry0.
  typedef struct packed {
    logic    valid0;
    logic    valid1;
    result_t entry0;
    result_t entry1;
  } push_t;

endpackage

`default_nettype wire

[hdl/stok_scanner.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "source_tokenizer_macros.svh"

module stok_scanner (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  input  logic          end_i,
  output stok_pkg::push_t push_o
);
  import stok_pkg::*;

  typedef enum logic [15:0] {
    ModeIdle      = 16'h0001,
    ModeIdent     = 16'h0002,
    ModeNumber    = 16'h0004,
    ModeSlash     = 16'h0008,
    ModeLine      = 16'h0010,
    ModeBlock     = 16'h0020,
    ModeBlockStar = 16'h0040,
    ModeString    = 16'h0080,
    ModeStringEsc = 16'h0100,
    ModeBang      = 16'h0200,
    ModeEq        = 16'h0400,
    ModeAmp       = 16'h0800,
    ModePipe      = 16'h1000,
    ModeLt        = 16'h2000,
    ModeGt        = 16'h4000,
    ModeDiscard   = 16'h8000
  } mode_e;

  localparam count_t CountOne = count_t'(1);
  localparam count_t CountMax = '1;

  function automatic count_t sat_inc(input count_t v);
    return (v == CountMax) ? CountMax : v + CountOne;
  endfunction

  function automatic logic [15:0] to16(input count_t v);
    logic [CountWidth+15:0] ext;
    ext = {16'b0, v};
    return ext[15:0];
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic kind_e ident_kind(input logic [47:0] kw_buf, input count_t len);
    kind_e k;
    k = TokIdent;
    if (len <= count_t'(KwMaxLen)) begin
      for (int i = 0; i < NumKeywords; i++) begin
        if ((len == count_t'(KwLen[i])) && (kw_buf == KwText[i])) begin
          k = kind_e'(6'(TokLet) + 6'(i));
        end
      end
    end
    return k;
  endfunction

  mode_e       mode_q, mode_d;
  count_t      line_q, line_d;
  count_t      col_q, col_d;
  count_t      len_q, len_d;
  logic [47:0] buf_q, buf_d;

  logic is_end;
  assign is_end = end_i || (byte_i == 8'd0);

  // Position after the current byte.
  count_t post_line, post_col;
  assign post_line = (byte_i == "\n") ? sat_inc(line_q) : line_q;
  assign post_col  = (byte_i == "\n") ? CountOne : sat_inc(col_q);

  // Token held pending by the current mode.
  logic   pend_v;
  kind_e  pend_kind;
  count_t pend_len;

  always_comb begin
    pend_v    = 1'b1;
    pend_kind = TokEnd;
    pend_len  = CountOne;
    case (mode_q)
      ModeIdent: begin
        pend_kind = ident_kind(buf_q, len_q);
        pend_len  = len_q;
      end
      ModeNumber: begin
        pend_kind = TokNumber;
        pend_len  = len_q;
      end
      ModeSlash: pend_kind = TokSlash;
      ModeBang:  pend_kind = TokBang;
      ModeEq:    pend_kind = TokAssign;
      ModeAmp:   pend_kind = TokAmp;
      ModePipe:  pend_kind = TokPipe;
      ModeLt:    pend_kind = TokLt;
      ModeGt:    pend_kind = TokGt;
      default: begin
        pend_v   = 1'b0;
        pend_len = '0;
      end
    endcase
  end

  // Scan of the byte from the idle mode.
  logic  id_emit, id_adv, id_ident, id_num, id_str, id_len;
  kind_e id_kind;
  err_e  id_err;
  mode_e id_mode;

  always_comb begin
    id_emit  = 1'b0;
    id_adv   = 1'b1;
    id_ident = 1'b0;
    id_num   = 1'b0;
    id_str   = 1'b0;
    id_len   = 1'b1;
    id_kind  = TokEnd;
    id_err   = ErrNone;
    id_mode  = ModeIdle;
    case (byte_i)
      "(":  begin id_emit = 1'b1; id_kind = TokLParen; end
      ")":  begin id_emit = 1'b1; id_kind = TokRParen; end
      "{":  begin id_emit = 1'b1; id_kind = TokLBrace; end
      "}":  begin id_emit = 1'b1; id_kind = TokRBrace; end
      ":":  begin id_emit = 1'b1; id_kind = TokColon; end
      ";":  begin id_emit = 1'b1; id_kind = TokSemi; end
      ",":  begin id_emit = 1'b1; id_kind = TokComma; end
      "+":  begin id_emit = 1'b1; id_kind = TokPlus; end
      "-":  begin id_emit = 1'b1; id_kind = TokMinus; end
      "*":  begin id_emit = 1'b1; id_kind = TokStar; end
      "%":  begin id_emit = 1'b1; id_kind = TokPct; end
      "^":  begin id_emit = 1'b1; id_kind = TokCaret; end
      "\"": begin id_mode = ModeString; id_str = 1'b1; end
      "/":  id_mode = ModeSlash;
      "!":  id_mode = ModeBang;
      "=":  id_mode = ModeEq;
      "&":  id_mode = ModeAmp;
      "|":  id_mode = ModePipe;
      "<":  id_mode = ModeLt;
      ">":  id_mode = ModeGt;
      default: begin
        if (is_space(byte_i)) begin
          id_mode = ModeIdle;
        end else if (is_alpha(byte_i) || (byte_i == "_")) begin
          id_mode  = ModeIdent;
          id_ident = 1'b1;
        end else if (is_digit(byte_i)) begin
          id_mode = ModeNumber;
          id_num  = 1'b1;
        end else begin
          // Unexpected byte: report at the position before it, then drop.
          id_emit = 1'b1;
          id_err  = ErrUnexpected;
          id_len  = 1'b0;
          id_adv  = 1'b0;
          id_mode = ModeDiscard;
        end
      end
    endcase
  end

  // Slot a: pending token, at the position before the byte.
  // Slot b: token closed by the byte, at the position after any advance.
  logic   a_v, b_v, do_adv, flush, take_idle;
  kind_e  a_kind, b_kind;
  err_e   b_err;
  count_t a_len, b_len;
  count_t b_line, b_col;

  always_comb begin
    mode_d    = mode_q;
    len_d     = len_q;
    buf_d     = buf_q;
    a_v       = 1'b0;
    a_kind    = TokEnd;
    a_len     = '0;
    b_v       = 1'b0;
    b_kind    = TokEnd;
    b_err     = ErrNone;
    b_len     = '0;
    do_adv    = 1'b0;
    flush     = 1'b0;
    take_idle = 1'b0;

    if (step_i && is_end) begin
      case (mode_q)
        ModeBlock, ModeBlockStar: begin
          b_v   = 1'b1;
          b_err = ErrOpenComment;
        end
        ModeString, ModeStringEsc: begin
          b_v   = 1'b1;
          b_err = ErrOpenString;
        end
        ModeDiscard: b_v = 1'b0;
        default: begin
          flush = 1'b1;
          b_v   = 1'b1;
        end
      endcase
    end else if (step_i) begin
      case (mode_q)
        ModeIdle: take_idle = 1'b1;
        ModeIdent: begin
          if (is_alpha(byte_i) || is_digit(byte_i) || (byte_i == "_")) begin
            if (len_q < count_t'(KwMaxLen)) begin
              buf_d = {buf_q[39:0], byte_i};
            end
            len_d  = sat_inc(len_q);
            do_adv = 1'b1;
          end else begin
            flush     = 1'b1;
            take_idle = 1'b1;
          end
        end
        ModeNumber: begin
          if (is_digit(byte_i)) begin
            len_d  = sat_inc(len_q);
            do_adv = 1'b1;
          end else begin
            flush     = 1'b1;
            take_idle = 1'b1;
          end
        end
        ModeSlash: begin
          if (byte_i == "/") begin
            do_adv = 1'b1;
            mode_d = ModeLine;
          end else if (byte_i == "*") begin
            do_adv = 1'b1;
            mode_d = ModeBlock;
          end else begin
            flush     = 1'b1;
            take_idle = 1'b1;
          end
        end
        ModeLine: begin
          do_adv = 1'b1;
          if (byte_i == "\n") mode_d = ModeIdle;
        end
        ModeBlock: begin
          do_adv = 1'b1;
          if (byte_i == "*") mode_d = ModeBlockStar;
        end
        ModeBlockStar: begin
          do_adv = 1'b1;
          if (byte_i == "/") begin
            mode_d = ModeIdle;
          end else if (byte_i != "*") begin
            mode_d = ModeBlock;
          end
        end
        ModeString: begin
          do_adv = 1'b1;
          if (byte_i == "\"") begin
            mode_d = ModeIdle;
            b_v    = 1'b1;
            b_kind = TokString;
            b_len  = len_q;
          end else begin
            len_d = sat_inc(len_q);
            if (byte_i == "\\") mode_d = ModeStringEsc;
          end
        end
        ModeStringEsc: begin
          do_adv = 1'b1;
          len_d  = sat_inc(len_q);
          mode_d = ModeString;
        end
        ModeBang, ModeEq, ModeAmp, ModePipe, ModeLt, ModeGt: begin
          b_len = count_t'(2);
          if ((mode_q == ModeLt) && (byte_i == "<")) begin
            b_kind = TokShl;
          end else if ((mode_q == ModeGt) && (byte_i == ">")) begin
            b_kind = TokShr;
          end else if ((mode_q == ModeAmp) && (byte_i == "&")) begin
            b_kind = TokAndAnd;
          end else if ((mode_q == ModePipe) && (byte_i == "|")) begin
            b_kind = TokOrOr;
          end else if ((byte_i == "=") && (mode_q == ModeBang)) begin
            b_kind = TokNe;
          end else if ((byte_i == "=") && (mode_q == ModeEq)) begin
            b_kind = TokEqEq;
          end else if ((byte_i == "=") && (mode_q == ModeLt)) begin
            b_kind = TokLe;
          end else if ((byte_i == "=") && (mode_q == ModeGt)) begin
            b_kind = TokGe;
          end else begin
            flush     = 1'b1;
            take_idle = 1'b1;
          end
          if (!take_idle) begin
            do_adv = 1'b1;
            mode_d = ModeIdle;
            b_v    = 1'b1;
          end
        end
        default: mode_d = mode_q;
      endcase
    end

    if (flush) begin
      a_v    = pend_v;
      a_kind = pend_kind;
      a_len  = pend_len;
    end

    if (take_idle) begin
      mode_d = id_mode;
      do_adv = id_adv;
      b_v    = id_emit;
      b_kind = id_kind;
      b_err  = id_err;
      b_len  = count_t'(id_len);
      if (id_ident) begin
        len_d = CountOne;
        buf_d = {40'b0, byte_i};
      end
      if (id_num) len_d = CountOne;
      if (id_str) len_d = '0;
    end

    b_line = do_adv ? post_line : line_q;
    b_col  = do_adv ? post_col : col_q;
    line_d = b_line;
    col_d  = b_col;

    // End of text: return to the reset state.
    if (step_i && is_end) begin
      mode_d = ModeIdle;
      line_d = CountOne;
      col_d  = CountOne;
      len_d  = '0;
      buf_d  = '0;
    end
  end

  // Compact the two slots so the first result always lands in entry0.
  result_t res_a, res_b;

  always_comb begin
    res_a.kind   = a_kind;
    res_a.err    = ErrNone;
    res_a.line   = to16(line_q);
    res_a.column = to16(col_q);
    res_a.length = to16(a_len);
    res_a.last   = !b_v;

    res_b.kind   = b_kind;
    res_b.err    = b_err;
    res_b.line   = to16(b_line);
    res_b.column = to16(b_col);
    res_b.length = to16(b_len);
    res_b.last   = 1'b1;

    push_o.valid0 = a_v || b_v;
    push_o.valid1 = a_v && b_v;
    push_o.entry0 = a_v ? res_a : res_b;
    push_o.entry1 = res_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      line_q <= CountOne;
      col_q  <= CountOne;
      len_q  <= '0;
      buf_q  <= '0;
    end else begin
      mode_q <= mode_d;
      line_q <= line_d;
      col_q  <= col_d;
      len_q  <= len_d;
      buf_q  <= buf_d;
    end
  end

  `STOK_ASSERT(a_second_needs_first, push_o.valid1 |-> push_o.valid0, "second result without first")
  `STOK_ASSERT(a_end_restarts, (step_i && is_end) |=> ((mode_q == ModeIdle) && (line_q == CountOne) && (col_q == CountOne)), "end did not restart scan")
  `STOK_ASSERT(a_pair_no_flush, (push_o.valid1 && (push_o.entry1.err != ErrNone)) |-> (push_o.entry0.err == ErrNone), "two errors in one step")

endmodule

`default_nettype wire

[hdl/stok_result_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "source_tokenizer_macros.svh"

module stok_result_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stok_pkg::push_t   push_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output stok_pkg::result_t head_o
);
  import stok_pkg::*;

  localparam int unsigned PtrWidth = $clog2(QueueDepth);
  localparam int unsigned CntWidth = $clog2(QueueDepth + 1);

  result_t entries_q [QueueDepth];

  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_next;
  logic [CntWidth-1:0] count_q, count_d;
  logic                pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign head_o      = entries_q[rd_ptr_q];
  // Accept a step only when two free slots are certain.
  assign room_o      = (count_q <= CntWidth'(QueueDepth - 2));

  assign wr_ptr_next = wr_ptr_q + PtrWidth'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrWidth'(push_i.valid0) + PtrWidth'(push_i.valid1);
    rd_ptr_d = rd_ptr_q + PtrWidth'(pop);
    count_d  = count_q + CntWidth'(push_i.valid0) + CntWidth'(push_i.valid1)
               - CntWidth'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid0) entries_q[wr_ptr_q] <= push_i.entry0;
    if (push_i.valid1) entries_q[wr_ptr_next] <= push_i.entry1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `STOK_ASSERT_ALWAYS(a_count_bound, (!rst_ni) || (count_q <= CntWidth'(QueueDepth)), "queue overflow")
  `STOK_ASSERT(a_pop_drains, (pop && !push_i.valid0) |=> (count_q == ($past(count_q) - CntWidth'(1))), "pop did not drain")

endmodule

`default_nettype wire

[hdl/source_tokenizer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Streaming tokenizer, one source byte per request.
// Input channel (in_valid_i / in_ready_o): source_byte_i plus end_of_source_i;
// a zero byte also ends the text. Output channel (out_valid_o / out_ready_i):
// one token or error result per request, with last_of_run_o set on the final
// result that an input byte caused. A byte causes zero, one or two results.
// A taken byte waits in the input register, is scanned there, and its results
// go to the result queue. Throughput: one byte per cycle while the queue has
// room, through the combinational scan step between the input register and
// the queue. The output side moves one result per cycle while out_ready_i is
// high, so a byte that closes two tokens at once gives it two results to move.
// A four-entry result queue separates the sides: input keeps flowing while
// results wait, and in_ready_o drops only when fewer than two slots are free.
// A stalled receiver therefore backs up into the input and no result is ever
// lost. After an end request the scanner is back in its reset state for the
// next text. Reset (rst_ni low) empties the input register and the queue and
// sets line and column to one.
module source_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  source_byte_i,
  input  logic        end_of_source_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  token_kind_o,
  output logic [1:0]  error_code_o,
  output logic [15:0] line_number_o,
  output logic [15:0] column_number_o,
  output logic [15:0] text_length_o,
  output logic        last_of_run_o
);
  import stok_pkg::*;

  // Input register: holds one request until the scanner takes it.
  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       end_q;
  logic       accept, room, step;

  push_t   push;
  result_t head;

  // Scan whenever a byte is held and the queue can take two results.
  assign step       = in_valid_q && room;
  assign in_ready_o = !in_valid_q || room;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Payload needs no reset: it is qualified by in_valid_q.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= source_byte_i;
      end_q  <= end_of_source_i;
    end
  end

  stok_scanner u_scanner (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (byte_q),
    .end_i  (end_q),
    .push_o (push)
  );

  stok_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign token_kind_o    = head.kind;
  assign error_code_o    = head.err;
  assign line_number_o   = head.line;
  assign column_number_o = head.column;
  assign text_length_o   = head.length;
  assign last_of_run_o   = head.last;

endmodule

`default_nettype wire

[bench/source_tokenizer_test.sv]
`timescale 1ns / 1ps

module source_tokenizer_test;
  import stok_pkg::*;

  // Hard stop on the cycle count. The slowest correct run, under the heaviest
  // stall mix with two results per byte, stays far below this.
  localparam int CycleLimit = 1000000;
  // Random requests per handshake phase that the scanner does not throw away.
  localparam int PhaseItems = 430;
  localparam int DirRows = 24;
  // Cap on printed mismatch lines; every mismatch is still counted.
  localparam int MaxReports = 60;

  // Scanner states of the bench model.
  typedef enum logic [3:0] {
    ScIdle, ScIdent, ScNumber, ScSlash, ScLine, ScBlock, ScBlockStar,
    ScString, ScStringEsc, ScBang, ScEq, ScAmp, ScPipe, ScLt, ScGt, ScDiscard
  } scan_e;

  // One row of the directed table. Rows with typed set carry the single
  // result they must give; all other rows are checked against the model.
  typedef struct packed {
    logic [7:0]  ch;
    logic        eos;
    logic        typed;
    kind_e       kind;
    err_e        err;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] length;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  src_byte = 8'h00;
  logic        src_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  tok_kind;
  logic [1:0]  tok_err;
  logic [15:0] tok_line;
  logic [15:0] tok_column;
  logic [15:0] tok_length;
  logic        tok_last;

  // Handshake pressure of the current phase, in percent of cycles.
  int idle_pct = 0;
  int stall_pct = 0;

  int fail_count = 0;
  int cycle_count = 0;
  int texts_sent = 0;
  int bytes_scanned = 0;
  int tokens_checked = 0;

  // Bench model state: scanner mode, position, token length, identifier bytes.
  scan_e       sc_mode = ScIdle;
  logic [15:0] sc_line = 16'd1;
  logic [15:0] sc_col = 16'd1;
  logic [15:0] sc_len = 16'd0;
  logic [47:0] sc_kw = 48'd0;

  result_t step_tokens [$];     // results of the request being modeled
  result_t pending_tokens [$];  // results still owed by the block, oldest first
  logic [8:0] text_q [$];       // {end flag, byte} of the text being sent

  string op_text [27] = '{
    "(", ")", "{", "}", ":", ";", ",", "+", "-", "*", "/", "%", "!", "!=",
    "=", "==", "&", "&&", "|", "||", "^", "<", "<<", "<=", ">", ">>", ">="
  };

  // Directed rows: reset state, end on a byte and on zero, an unexpected
  // byte with discarding up to the end, an unterminated string with escapes,
  // the slash-star-slash comment left open, a keyword closed by a pair
  // operator, a bang closed by a newline, and a number closed by a
  // non-ASCII byte, which gives two results at once.
  dir_row_t dir_table [DirRows] = '{
    '{8'hFF, 1'b1, 1'b1, TokEnd, ErrNone, 16'd1, 16'd1, 16'd0},
    '{"(", 1'b0, 1'b1, TokLParen, ErrNone, 16'd1, 16'd2, 16'd1},
    '{8'h00, 1'b0, 1'b1, TokEnd, ErrNone, 16'd1, 16'd2, 16'd0},
    '{8'h80, 1'b0, 1'b1, TokEnd, ErrUnexpected, 16'd1, 16'd1, 16'd0},
    '{"a", 1'b0, 1'b0, TokEnd, ErrNone, 16'd0, 16'd0, 16'd0},
    '{8'h00, 1'b1, 1'b0, TokEnd, ErrNone, 16'd0, 16'd0, 16'd0},
    '{"\"", 1'b0, 1'b0, TokEnd, ErrNone, 16'd0, 16'd0, 16'd0},
    '{"\\", 1'b0, 1'b0, TokEnd, ErrNone, 16'd0, 16'd0, 16'd0},
    '{"\"", 1'b0, 1'b0, TokEnd, ErrNone, 16'd0, 16'd0, 16'd0},
    '{8'h00, 1'b1, 1'b1, TokEnd, ErrOpenString, 16'd1, 16'd4, 16'd0},
    '{"/", 1'b0, 1'b0, TokEnd, ErrNone, 16'd0, 16'd0, 16'd0},
    '{"*", 1'b0, 1'b0, TokEnd, ErrNone, 16'd0, 16'd0, 16'd0},
    '{"/", 1'b0, 1'b0, TokEnd, ErrNone, 16'd0, 16'd0, 16'd0},
    '{8'h00, 1'b0, 1'b1, TokEnd, ErrOpenComment, 16'd1, 16'd4, 16'd0},
    '{"l", 1'b0, 1'b0, TokEnd, ErrNone, 16'd0, 16'd0, 16'd0},
    '{"e", 1'b0, 1'b0, TokEnd, ErrNone, 16'd0, 16'd0, 16'd0},
    '{"t", 1'b0, 1'b0, TokEnd, ErrNone, 16'd0, 16'd0, 16'd0},
    '{">", 1'b0, 1'b0, TokEnd, ErrNone, 16'd0, 16'd0, 16'd0},
    '{"=", 1'b0, 1'b0, TokEnd, ErrNone, 16'd0, 16'd0, 16'd0},
    '{"!", 1'b0, 1'b0, TokEnd, ErrNone, 16'd0, 16'd0, 16'd0},
    '{"\n", 1'b0, 1'b0, TokEnd, ErrNone, 16'd0, 16'd0, 16'd0},
    '{"7", 1'b0, 1'b0, TokEnd, ErrNone, 16'd0, 16'd0, 16'd0},
    '{8'hFF, 1'b0, 1'b0, TokEnd, ErrNone, 16'd0, 16'd0, 16'd0},
    '{8'h7F, 1'b1, 1'b0, TokEnd, ErrNone, 16'd0, 16'd0, 16'd0}
  };

  source_tokenizer dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .source_byte_i   (src_byte),
    .end_of_source_i (src_end),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .token_kind_o    (tok_kind),
    .error_code_o    (tok_err),
    .line_number_o   (tok_line),
    .column_number_o (tok_column),
    .text_length_o   (tok_length),
    .last_of_run_o   (tok_last)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Bench model of the scanner
  // ---------------------------------------------------------------------

  function automatic logic [15:0] sat16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Resolve a finished identifier: only exact matches of six bytes or fewer
  // are keywords.
  function automatic kind_e word_kind();
    if (sc_len > 16'd6) return TokIdent;
    if (sc_len == 16'd3 && sc_kw == {24'd0, "let"}) return TokLet;
    if (sc_len == 16'd2 && sc_kw == {32'd0, "fn"}) return TokFn;
    if (sc_len == 16'd2 && sc_kw == {32'd0, "if"}) return TokIf;
    if (sc_len == 16'd4 && sc_kw == {16'd0, "else"}) return TokElse;
    if (sc_len == 16'd5 && sc_kw == {8'd0, "while"}) return TokWhile;
    if (sc_len == 16'd6 && sc_kw == "return") return TokReturn;
    if (sc_len == 16'd4 && sc_kw == {16'd0, "true"}) return TokTrue;
    if (sc_len == 16'd5 && sc_kw == {8'd0, "false"}) return TokFalse;
    return TokIdent;
  endfunction

  task automatic lex_post(input kind_e k, input err_e e, input logic [15:0] len);
    result_t r;
    r.kind = k;
    r.err = e;
    r.line = sc_line;
    r.column = sc_col;
    r.length = len;
    r.last = 1'b0;
    step_tokens = {step_tokens, r};
  endtask

  // Advance the position past one byte.
  task automatic lex_bump(input logic [7:0] c);
    if (c == "\n") begin
      sc_line = sat16(sc_line);
      sc_col = 16'd1;
    end else begin
      sc_col = sat16(sc_col);
    end
  endtask

  // Emit the token that was waiting for its closing byte, if any.
  task automatic lex_flush();
    case (sc_mode)
      ScIdent: lex_post(word_kind(), ErrNone, sc_len);
      ScNumber: lex_post(TokNumber, ErrNone, sc_len);
      ScSlash: lex_post(TokSlash, ErrNone, 16'd1);
      ScBang: lex_post(TokBang, ErrNone, 16'd1);
      ScEq: lex_post(TokAssign, ErrNone, 16'd1);
      ScAmp: lex_post(TokAmp, ErrNone, 16'd1);
      ScPipe: lex_post(TokPipe, ErrNone, 16'd1);
      ScLt: lex_post(TokLt, ErrNone, 16'd1);
      ScGt: lex_post(TokGt, ErrNone, 16'd1);
      default: ;
    endcase
    sc_mode = ScIdle;
  endtask

  task automatic lex_idle(input logic [7:0] c);
    kind_e k;
    bit single;
    single = 1'b1;
    k = TokEnd;
    case (c)
      "(": k = TokLParen;
      ")": k = TokRParen;
      "{": k = TokLBrace;
      "}": k = TokRBrace;
      ":": k = TokColon;
      ";": k = TokSemi;
      ",": k = TokComma;
      "+": k = TokPlus;
      "-": k = TokMinus;
      "*": k = TokStar;
      "%": k = TokPct;
      "^": k = TokCaret;
      default: single = 1'b0;
    endcase
    if (single) begin
      lex_bump(c);
      lex_post(k, ErrNone, 16'd1);
      return;
    end
    if (is_space(c)) begin
      lex_bump(c);
      return;
    end
    if (is_alpha(c) || c == "_") begin
      lex_bump(c);
      sc_mode = ScIdent;
      sc_len = 16'd1;
      sc_kw = {40'd0, c};
      return;
    end
    if (is_digit(c)) begin
      lex_bump(c);
      sc_mode = ScNumber;
      sc_len = 16'd1;
      return;
    end
    case (c)
      "\"": begin
        sc_mode = ScString;
        sc_len = 16'd0;
      end
      "/": sc_mode = ScSlash;
      "!": sc_mode = ScBang;
      "=": sc_mode = ScEq;
      "&": sc_mode = ScAmp;
      "|": sc_mode = ScPipe;
      "<": sc_mode = ScLt;
      ">": sc_mode = ScGt;
      default: begin
        // Report at the position before the byte, then drop the rest.
        lex_post(TokEnd, ErrUnexpected, 16'd0);
        sc_mode = ScDiscard;
        return;
      end
    endcase
    lex_bump(c);
  endtask

  task automatic lex_pair(input logic [7:0] c, input logic [7:0] second, input kind_e pair);
    if (c == second) begin
      lex_bump(c);
      sc_mode = ScIdle;
      lex_post(pair, ErrNone, 16'd2);
    end else begin
      lex_flush();
      lex_idle(c);
    end
  endtask

  task automatic lex_byte(input logic [7:0] c);
    case (sc_mode)
      ScIdle: lex_idle(c);
      ScIdent: begin
        if (is_alpha(c) || is_digit(c) || c == "_") begin
          if (sc_len < 16'd6) sc_kw = {sc_kw[39:0], c};
          sc_len = sat16(sc_len);
          lex_bump(c);
        end else begin
          lex_flush();
          lex_idle(c);
        end
      end
      ScNumber: begin
        if (is_digit(c)) begin
          sc_len = sat16(sc_len);
          lex_bump(c);
        end else begin
          lex_flush();
          lex_idle(c);
        end
      end
      ScSlash: begin
        if (c == "/") begin
          lex_bump(c);
          sc_mode = ScLine;
        end else if (c == "*") begin
          lex_bump(c);
          sc_mode = ScBlock;
        end else begin
          lex_flush();
          lex_idle(c);
        end
      end
      ScLine: begin
        if (c == "\n") sc_mode = ScIdle;
        lex_bump(c);
      end
      ScBlock: begin
        if (c == "*") sc_mode = ScBlockStar;
        lex_bump(c);
      end
      ScBlockStar: begin
        if (c == "/") sc_mode = ScIdle;
        else if (c != "*") sc_mode = ScBlock;
        lex_bump(c);
      end
      ScString: begin
        lex_bump(c);
        if (c == "\"") begin
          sc_mode = ScIdle;
          lex_post(TokString, ErrNone, sc_len);
        end else begin
          sc_len = sat16(sc_len);
          if (c == "\\") sc_mode = ScStringEsc;
        end
      end
      ScStringEsc: begin
        lex_bump(c);
        sc_len = sat16(sc_len);
        sc_mode = ScString;
      end
      ScBang: lex_pair(c, "=", TokNe);
      ScEq: lex_pair(c, "=", TokEqEq);
      ScAmp: lex_pair(c, "&", TokAndAnd);
      ScPipe: lex_pair(c, "|", TokOrOr);
      ScLt: begin
        if (c == "<") begin
          lex_bump(c);
          sc_mode = ScIdle;
          lex_post(TokShl, ErrNone, 16'd2);
        end else begin
          lex_pair(c, "=", TokLe);
        end
      end
      ScGt: begin
        if (c == ">") begin
          lex_bump(c);
          sc_mode = ScIdle;
          lex_post(TokShr, ErrNone, 16'd2);
        end else begin
          lex_pair(c, "=", TokGe);
        end
      end
      default: ;  // discarding until the end
    endcase
  endtask

  // Model one request; its results land in step_tokens, the last one marked.
  task automatic lex_request(input logic [7:0] c, input logic eos);
    result_t r;
    step_tokens.delete();
    if (eos || c == 8'h00) begin
      if (sc_mode == ScBlock || sc_mode == ScBlockStar) begin
        lex_post(TokEnd, ErrOpenComment, 16'd0);
      end else if (sc_mode == ScString || sc_mode == ScStringEsc) begin
        lex_post(TokEnd, ErrOpenString, 16'd0);
      end else if (sc_mode != ScDiscard) begin
        lex_flush();
        lex_post(TokEnd, ErrNone, 16'd0);
      end
      // Back to the reset state for the next text.
      sc_mode = ScIdle;
      sc_line = 16'd1;
      sc_col = 16'd1;
      sc_len = 16'd0;
      sc_kw = 48'd0;
    end else begin
      lex_byte(c);
    end
    if (step_tokens.size() > 0) begin
      r = step_tokens.pop_back();
      r.last = 1'b1;
      step_tokens = {step_tokens, r};
    end
  endtask

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Present one request, with random idle cycles in front, and hold it until
  // the block takes it. Returns at the accepting edge, valid still high.
  task automatic put_request(input logic [7:0] c, input logic eos);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    src_byte <= c;
    src_end <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Send one request and queue the results the model gives for it.
  task automatic feed(input logic [7:0] c, input logic eos);
    put_request(c, eos);
    if (sc_mode != ScDiscard) bytes_scanned++;
    if (eos || c == 8'h00) texts_sent++;
    lex_request(c, eos);
    pending_tokens = {pending_tokens, step_tokens};
    step_tokens.delete();
  endtask

  // ---------------------------------------------------------------------
  // Random text generation
  // ---------------------------------------------------------------------

  task automatic put_ch(input logic [7:0] c);
    logic [8:0] entry;
    entry = {1'b0, c};
    text_q = {text_q, entry};
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put_ch(s[i]);
  endtask

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(62);
    if (r < 26) return 8'h61 + 8'(r);
    if (r < 52) return 8'h41 + 8'(r - 26);
    if (r < 62) return 8'h30 + 8'(r - 52);
    return "_";
  endfunction

  function automatic logic [7:0] space_char();
    int r;
    r = $urandom_range(5);
    if (r == 5) return " ";
    return 8'd9 + 8'(r);
  endfunction

  // Any nonzero byte, quote and backslash replaced.
  function automatic logic [7:0] string_char();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    if (c == "\"" || c == "\\") c = "q";
    return c;
  endfunction

  task automatic add_fragment();
    int pick;
    int n;
    logic [7:0] c;
    pick = $urandom_range(99);
    if (pick < 12) begin
      case ($urandom_range(7))
        0: put_str("let");
        1: put_str("fn");
        2: put_str("if");
        3: put_str("else");
        4: put_str("while");
        5: put_str("return");
        6: put_str("true");
        default: put_str("false");
      endcase
      // Sometimes spoil it, so near-miss and over-long words show up.
      if ($urandom_range(3) == 0) put_ch(word_char());
    end else if (pick < 24) begin
      c = word_char();
      if (is_digit(c)) c = "_";
      put_ch(c);
      n = ($urandom_range(7) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
      for (int i = 0; i < n; i++) put_ch(word_char());
    end else if (pick < 33) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) put_ch(8'h30 + 8'($urandom_range(9)));
    end else if (pick < 43) begin
      put_ch("\"");
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(9))
          0, 1: begin
            put_ch("\\");
            put_ch(8'($urandom_range(1, 255)));
          end
          2: put_ch("\n");
          default: put_ch(string_char());
        endcase
      end
      put_ch("\"");
    end else if (pick < 70) begin
      put_str(op_text[$urandom_range(26)]);
    end else if (pick < 80) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) put_ch(space_char());
    end else if (pick < 87) begin
      put_str("//");
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) begin
        c = 8'($urandom_range(1, 255));
        put_ch((c == "\n") ? 8'h20 : c);
      end
      if ($urandom_range(9) != 0) put_ch("\n");
    end else if (pick < 98) begin
      // Block comment; sometimes led by a slash right after the opening star.
      put_str(($urandom_range(4) == 0) ? "/*/" : "/*");
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(5))
          0: put_ch("*");
          1: put_ch("/");
          2: put_ch("\n");
          default: put_ch(8'($urandom_range(1, 255)));
        endcase
      end
      put_str(($urandom_range(3) == 0) ? "**/" : "*/");
    end else begin
      // Noise: any nonzero byte, often one the scanner rejects.
      put_ch(8'($urandom_range(1, 255)));
    end
  endtask

  task automatic build_text();
    int frags;
    int r;
    logic [8:0] tail;
    text_q.delete();
    frags = $urandom_range(1, 16);
    for (int i = 0; i < frags; i++) begin
      add_fragment();
      if ($urandom_range(1) == 0) put_ch(space_char());
    end
    r = $urandom_range(99);
    if (r >= 94) begin
      // Leave a string or a block comment open at the end.
      if (r[0]) put_str("\"ab\\");
      else put_str("/* x*");
    end
    if (r < 80 || r >= 94) tail = {1'b1, 8'($urandom_range(255))};
    else tail = {1'b0, 8'h00};
    text_q = {text_q, tail};
  endtask

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      if (fail_count < MaxReports)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Random backpressure on the result channel.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare every accepted result with the oldest owed one.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_tokens.size() == 0) begin
        if (fail_count < MaxReports)
          $display("%0t: unexpected result, kind %0d error %0d line %0d column %0d",
                   $time, tok_kind, tok_err, tok_line, tok_column);
        fail_count++;
      end else begin
        want = pending_tokens.pop_front();
        tokens_checked++;
        check_field("token_kind", int'(want.kind), int'(tok_kind));
        check_field("error_code", int'(want.err), int'(tok_err));
        check_field("line_number", int'(want.line), int'(tok_line));
        check_field("column_number", int'(want.column), int'(tok_column));
        check_field("text_length", int'(want.length), int'(tok_length));
        check_field("last_of_run", int'(want.last), int'(tok_last));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still owed",
               cycle_count, pending_tokens.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin
    dir_row_t   row;
    result_t    typed_r;
    logic [8:0] item;
    int         phase_start;

    // Hold reset at the start, then release it once for the whole run.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: typed rows are checked against the listed values,
    // the rest against the model.
    foreach (dir_table[i]) begin
      row = dir_table[i];
      put_request(row.ch, row.eos);
      bytes_scanned++;
      if (row.eos || row.ch == 8'h00) texts_sent++;
      lex_request(row.ch, row.eos);
      if (row.typed) begin
        typed_r.kind = row.kind;
        typed_r.err = row.err;
        typed_r.line = row.line;
        typed_r.column = row.column;
        typed_r.length = row.length;
        typed_r.last = 1'b1;
        pending_tokens = {pending_tokens, typed_r};
      end else begin
        pending_tokens = {pending_tokens, step_tokens};
        step_tokens.delete();
      end
    end

    // Random texts under four handshake mixes.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 82; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 82; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      phase_start = bytes_scanned;
      while (bytes_scanned - phase_start < PhaseItems) begin
        build_text();
        while (text_q.size() > 0) begin
          item = text_q.pop_front();
          feed(item[7:0], item[8]);
        end
      end
    end

    // Drop valid, drain what is owed, then watch a little longer for strays.
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Scanned %0d bytes in %0d texts and checked %0d results,",
             bytes_scanned, texts_sent, tokens_checked);
    $display("covering open comments and strings, discarding, and four valid/ready mixes.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
